[design/y86isd_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the y86 instruction stream decoder
package y86isd_pkg;

    // window geometry
    localparam int NUM_BYTES = 10;
    typedef logic [NUM_BYTES-1:0][7:0] t_window;

    // result kinds
    localparam logic [2:0] KIND_INSTR  = 3'd0;
    localparam logic [2:0] KIND_MARKER = 3'd1;
    localparam logic [2:0] KIND_QUAD   = 3'd2;
    localparam logic [2:0] KIND_BYTE   = 3'd3;
    localparam logic [2:0] KIND_SKIP   = 3'd4;

    // instruction codes
    localparam logic [3:0] IC_HALT   = 4'h0;
    localparam logic [3:0] IC_NOP    = 4'h1;
    localparam logic [3:0] IC_CMOV   = 4'h2;
    localparam logic [3:0] IC_IRMOV  = 4'h3;
    localparam logic [3:0] IC_RMMOV  = 4'h4;
    localparam logic [3:0] IC_MRMOV  = 4'h5;
    localparam logic [3:0] IC_OPQ    = 4'h6;
    localparam logic [3:0] IC_JXX    = 4'h7;
    localparam logic [3:0] IC_CALL   = 4'h8;
    localparam logic [3:0] IC_RET    = 4'h9;
    localparam logic [3:0] IC_PUSH   = 4'hA;
    localparam logic [3:0] IC_POP    = 4'hB;
    localparam logic [3:0] IC_LIMIT  = 4'hC;

    // field limits
    localparam logic [3:0] FN_MAX    = 4'h6;
    localparam logic [3:0] REG_MAX   = 4'hE;
    localparam logic [3:0] NO_REG    = 4'hF;

    // lengths
    localparam logic [3:0] LEN_ONE   = 4'd1;
    localparam logic [3:0] LEN_TWO   = 4'd2;
    localparam logic [3:0] LEN_QUAD  = 4'd8;
    localparam logic [3:0] LEN_JUMP  = 4'd9;
    localparam logic [3:0] LEN_LONG  = 4'd10;

    // output queue depth, a power of two of at least four
    localparam int FIFO_DEPTH = 4;

    // decode of one window
    typedef struct packed {
        logic [3:0]  len;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] cst;
    } t_decode;

    // one result transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] item_address;
        logic [3:0]  op_code;
        logic [2:0]  op_function;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] cst;
        logic [3:0]  length;
        logic        last;
    } t_result;

    typedef t_result [1:0] t_result_pair;

endpackage

[design/y86isd_decode.sv]
`timescale 1ns / 1ps
// single instruction decode of one byte window
module y86isd_decode (
    input  y86isd_pkg::t_window i_window,
    input  logic [3:0]          i_count,
    output y86isd_pkg::t_decode o_dec
);
    import y86isd_pkg::*;

    logic [3:0] ic;
    logic [3:0] fn;
    logic [3:0] hi;
    logic [3:0] lo;
    logic       fn_ok;

    assign ic = i_window[0][7:4];
    assign fn = i_window[0][3:0];
    assign hi = i_window[1][7:4];
    assign lo = i_window[1][3:0];

    // function nibble check per class
    always_comb begin
        if (ic == IC_CMOV || ic == IC_OPQ || ic == IC_JXX) begin
            fn_ok = (fn <= FN_MAX);
        end else begin
            fn_ok = (fn == 4'h0);
        end
    end

    // length, registers and constant per class
    always_comb begin
        o_dec.len   = 4'd0;
        o_dec.reg_a = NO_REG;
        o_dec.reg_b = NO_REG;
        o_dec.cst   = 64'd0;
        if (ic < IC_LIMIT && fn_ok) begin
            case (ic)
                IC_HALT, IC_NOP, IC_RET: begin
                    o_dec.len = LEN_ONE;
                end
                IC_CMOV, IC_OPQ: begin
                    if (i_count >= LEN_TWO && hi <= REG_MAX && lo <= REG_MAX) begin
                        o_dec.len   = LEN_TWO;
                        o_dec.reg_a = hi;
                        o_dec.reg_b = lo;
                    end
                end
                IC_IRMOV: begin
                    if (i_count >= LEN_LONG && hi == NO_REG && lo <= REG_MAX) begin
                        o_dec.len   = LEN_LONG;
                        o_dec.reg_a = hi;
                        o_dec.reg_b = lo;
                        o_dec.cst   = i_window[9:2];
                    end
                end
                IC_RMMOV, IC_MRMOV: begin
                    if (i_count >= LEN_LONG && hi <= REG_MAX && lo <= REG_MAX) begin
                        o_dec.len   = LEN_LONG;
                        o_dec.reg_a = hi;
                        o_dec.reg_b = lo;
                        o_dec.cst   = i_window[9:2];
                    end
                end
                IC_JXX, IC_CALL: begin
                    if (i_count >= LEN_JUMP) begin
                        o_dec.len = LEN_JUMP;
                        o_dec.cst = i_window[8:1];
                    end
                end
                IC_PUSH, IC_POP: begin
                    if (i_count >= LEN_TWO && hi <= REG_MAX && lo == NO_REG) begin
                        o_dec.len   = LEN_TWO;
                        o_dec.reg_a = hi;
                        o_dec.reg_b = lo;
                    end
                end
                default: begin
                    o_dec.len = 4'd0;
                end
            endcase
        end
    end

endmodule

[design/y86isd_ctrl.sv]
`timescale 1ns / 1ps
// stream state and result forming for one window per cycle while i_go is high
module y86isd_ctrl #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  y86isd_pkg::t_window      i_window,
    input  logic [3:0]               i_count,
    input  logic                     i_cfg_we,
    input  logic [31:0]              i_cfg_data,
    output y86isd_pkg::t_result_pair o_res,
    output logic [1:0]               o_num
);
    import y86isd_pkg::*;

    logic [ADDR_WIDTH-1:0] r_addr;
    logic                  r_at_start;
    logic                  r_prev_halt;
    logic                  r_in_halt_run;
    logic                  r_finished;

    logic [ADDR_WIDTH-1:0] n_addr;
    logic                  n_at_start;
    logic                  n_prev_halt;
    logic                  n_in_halt_run;
    logic                  n_finished;

    logic [3:0]  cnt_sat;
    logic [3:0]  ic;
    logic [31:0] addr32;
    logic        addr_nz;
    t_decode     dec;
    t_result     marker;
    t_result     item;

    y86isd_decode u_decode (
        .i_window (i_window),
        .i_count  (cnt_sat),
        .o_dec    (dec)
    );

    assign cnt_sat = (i_count > LEN_LONG) ? LEN_LONG : i_count;
    assign ic      = i_window[0][7:4];
    assign addr32  = 32'(r_addr);
    assign addr_nz = (r_addr != '0);

    // non-instruction result template
    function automatic t_result blank(input logic [2:0] kind, input logic [31:0] addr,
                                      input logic [3:0] len);
        t_result r;
        r              = '0;
        r.kind         = kind;
        r.item_address = addr;
        r.reg_a        = NO_REG;
        r.reg_b        = NO_REG;
        r.length       = len;
        return r;
    endfunction

    // next state and results of the window
    always_comb begin
        n_addr        = r_addr;
        n_at_start    = r_at_start;
        n_prev_halt   = r_prev_halt;
        n_in_halt_run = r_in_halt_run;
        n_finished    = r_finished;
        marker        = blank(KIND_MARKER, addr32, 4'd0);
        item          = blank(KIND_BYTE, addr32, LEN_ONE);
        o_res[0]      = marker;
        o_res[1]      = item;
        o_num         = 2'd0;
        if (!r_finished) begin
            if (cnt_sat == 4'd0) begin
                // end of stream
                n_finished    = 1'b1;
                n_in_halt_run = 1'b0;
                n_prev_halt   = 1'b0;
                if (r_in_halt_run || (r_at_start && addr_nz)) begin
                    o_res[0]      = marker;
                    o_res[0].last = 1'b1;
                    o_num         = 2'd1;
                end
            end else if (r_at_start && i_window[0] == 8'h00) begin
                // leading zero byte
                o_res[0]      = blank(KIND_SKIP, addr32, LEN_ONE);
                o_res[0].last = 1'b1;
                o_num         = 2'd1;
                n_addr        = r_addr + ADDR_WIDTH'(1);
            end else begin
                n_at_start = 1'b0;
                if (ic != IC_HALT) begin
                    n_in_halt_run = 1'b0;
                    n_prev_halt   = 1'b0;
                end
                // item proper
                if (dec.len != 4'd0) begin
                    if (ic == IC_HALT && r_prev_halt) begin
                        n_in_halt_run = 1'b1;
                        item          = blank(KIND_SKIP, addr32, LEN_ONE);
                    end else begin
                        if (ic == IC_HALT) begin
                            n_prev_halt = 1'b1;
                        end
                        item             = blank(KIND_INSTR, addr32, dec.len);
                        item.op_code     = ic;
                        item.op_function = i_window[0][2:0];
                        item.reg_a       = dec.reg_a;
                        item.reg_b       = dec.reg_b;
                        item.cst         = dec.cst;
                    end
                end else if (r_addr[2:0] == 3'd0 && cnt_sat >= LEN_QUAD) begin
                    item     = blank(KIND_QUAD, addr32, LEN_QUAD);
                    item.cst = i_window[7:0];
                end else begin
                    item     = blank(KIND_BYTE, addr32, LEN_ONE);
                    item.cst = {56'd0, i_window[0]};
                end
                item.last = 1'b1;
                n_addr    = r_addr + ADDR_WIDTH'(item.length);
                // marker ahead of the item at a nonzero start or ending a halt run
                if ((r_at_start && addr_nz) || (ic != IC_HALT && r_in_halt_run)) begin
                    o_res[0] = marker;
                    o_res[1] = item;
                    o_num    = 2'd2;
                end else begin
                    o_res[0] = item;
                    o_num    = 2'd1;
                end
            end
        end
        if (!i_go) begin
            o_num = 2'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr        <= '0;
            r_at_start    <= 1'b1;
            r_prev_halt   <= 1'b0;
            r_in_halt_run <= 1'b0;
            r_finished    <= 1'b0;
        end else if (i_cfg_we) begin
            r_addr        <= ADDR_WIDTH'(i_cfg_data);
            r_at_start    <= 1'b1;
            r_prev_halt   <= 1'b0;
            r_in_halt_run <= 1'b0;
            r_finished    <= 1'b0;
        end else if (i_go) begin
            r_addr        <= n_addr;
            r_at_start    <= n_at_start;
            r_prev_halt   <= n_prev_halt;
            r_in_halt_run <= n_in_halt_run;
            r_finished    <= n_finished;
        end
    end

endmodule

[design/y86isd_fifo.sv]
`timescale 1ns / 1ps
// result queue taking up to two transactions per cycle and giving one
module y86isd_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [1:0]               i_push_num,
    input  y86isd_pkg::t_result_pair i_push_data,
    input  logic                     i_pop,
    output logic                     o_room,
    output logic                     o_valid,
    output y86isd_pkg::t_result      o_head
);
    import y86isd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic               pop_ok;

    assign wr_ptr_1 = r_wr_ptr + PTR_W'(1);
    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign pop_ok   = i_pop && o_valid;

    // room for two more after this cycle's pop
    assign o_room = (r_count <= CNT_W'(FIFO_DEPTH - 2)) ||
                    (pop_ok && r_count <= CNT_W'(FIFO_DEPTH - 1));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push_data[0];
        end
        if (i_push_num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push_data[1];
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_num);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop_ok);
            r_count  <= r_count + CNT_W'(i_push_num) - CNT_W'(pop_ok);
        end
    end

endmodule

[design/y86_instruction_stream_decoder.sv]
`timescale 1ns / 1ps
// top level of the y86-64 instruction stream decoder
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_byte_0..i_byte_9, i_bytes_valid
//   out      output     o_out_valid / i_out_stall o_kind .. o_last
//   cfg      input      i_cfg_we                  i_cfg_data (start offset)
//
// one window per cycle while the queue has room: a window is held in the input register,
// is decoded and queued, and its first result is offered from the result queue.
// a window gives up to two results; the four-entry queue drains one per unstalled cycle.
// reset is synchronous; decoding starts at address zero until the start offset is written.
// a stalled output fills the queue, then the input register holds and o_in_stall rises.
module y86_instruction_stream_decoder #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_0,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    input  logic [7:0]  i_byte_8,
    input  logic [7:0]  i_byte_9,
    input  logic [3:0]  i_bytes_valid,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_item_address,
    output logic [3:0]  o_op_code,
    output logic [2:0]  o_op_function,
    output logic [3:0]  o_reg_a,
    output logic [3:0]  o_reg_b,
    output logic [63:0] o_constant,
    output logic [3:0]  o_length,
    output logic        o_last
);
    import y86isd_pkg::*;

    logic         r_in_vld;
    t_window      r_window;
    logic [3:0]   r_count;

    logic         in_accept;
    logic         go;
    logic         room;
    logic         pop;
    t_result_pair res;
    logic [1:0]   res_num;
    t_result      head;

    assign go         = r_in_vld && room;
    assign o_in_stall = r_in_vld && !room;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_window <= {i_byte_9, i_byte_8, i_byte_7, i_byte_6, i_byte_5,
                         i_byte_4, i_byte_3, i_byte_2, i_byte_1, i_byte_0};
            r_count  <= i_bytes_valid;
        end
    end

    // decode and stream state
    y86isd_ctrl #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_window   (r_window),
        .i_count    (r_count),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_res      (res),
        .o_num      (res_num)
    );

    // result queue
    y86isd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_num  (res_num),
        .i_push_data (res),
        .i_pop       (pop),
        .o_room      (room),
        .o_valid     (o_out_valid),
        .o_head      (head)
    );

    // output fields
    assign o_kind         = head.kind;
    assign o_item_address = head.item_address;
    assign o_op_code      = head.op_code;
    assign o_op_function  = head.op_function;
    assign o_reg_a        = head.reg_a;
    assign o_reg_b        = head.reg_b;
    assign o_constant     = head.cst;
    assign o_length       = head.length;
    assign o_last         = head.last;

    // markers consume nothing
    a_marker_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_MARKER) |-> (o_length == 4'd0))
        else $error("position marker with nonzero length");

    // quad data only at aligned addresses and eight bytes long
    a_quad_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_QUAD) |->
        (o_item_address[2:0] == 3'd0 && o_length == LEN_QUAD))
        else $error("quad data misaligned or wrong length");

    // non-instruction results carry no opcode or registers
    a_non_instr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_INSTR) |->
        (o_op_code == 4'h0 && o_reg_a == NO_REG && o_reg_b == NO_REG))
        else $error("non-instruction result with instruction fields");

    // a held window never gets dropped while the queue lacks room
    a_hold_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !room) |=> r_in_vld)
        else $error("stalled window lost");

endmodule

[bench/y86_instruction_stream_decoder_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the y86 instruction stream decoder
module y86_instruction_stream_decoder_tb;
    import y86isd_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_PRINTED = 40;
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] COUNT_END = 4'd0;
    localparam logic [3:0] NO_OPC = 4'h0;
    localparam logic [3:0] FN_PLAIN = 4'h0;

    // clock, reset and channel signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_window     in_window = '0;
    logic [3:0]  in_count = '0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [31:0] o_item_address;
    logic [3:0]  o_op_code;
    logic [2:0]  o_op_function;
    logic [3:0]  o_reg_a;
    logic [3:0]  o_reg_b;
    logic [63:0] o_constant;
    logic [3:0]  o_length;
    logic        o_last;

    // decoder state as the bench tracks it
    logic [31:0] dec_addr = '0;
    bit          dec_at_start = 1'b1;
    bit          dec_prev_halt = 1'b0;
    bit          dec_halt_run = 1'b0;
    bit          dec_done = 1'b0;

    t_result     results_due[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          hold_off_left = 0;
    bit          gaps_on = 1'b1;
    int          burst_left = 0;

    // memory image of the current stream and its load address
    logic [7:0]  image[$];
    logic [31:0] image_base = '0;

    y86_instruction_stream_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_0       (in_window[0]),
        .i_byte_1       (in_window[1]),
        .i_byte_2       (in_window[2]),
        .i_byte_3       (in_window[3]),
        .i_byte_4       (in_window[4]),
        .i_byte_5       (in_window[5]),
        .i_byte_6       (in_window[6]),
        .i_byte_7       (in_window[7]),
        .i_byte_8       (in_window[8]),
        .i_byte_9       (in_window[9]),
        .i_bytes_valid  (in_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_item_address (o_item_address),
        .o_op_code      (o_op_code),
        .o_op_function  (o_op_function),
        .o_reg_a        (o_reg_a),
        .o_reg_b        (o_reg_b),
        .o_constant     (o_constant),
        .o_length       (o_length),
        .o_last         (o_last)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // little-endian quad starting at a window byte
    function automatic logic [63:0] quad_from(input t_window w, input int first);
        logic [63:0] v;
        v = '0;
        for (int i = 7; i >= 0; i--) v = {v[55:0], w[first + i]};
        return v;
    endfunction

    function automatic t_result make_result(input logic [2:0] kind, input logic [31:0] addr,
            input logic [3:0] opc, input logic [3:0] fn, input logic [3:0] ra,
            input logic [3:0] rb, input logic [63:0] c, input logic [3:0] len);
        t_result r;
        r.kind = kind;
        r.item_address = addr;
        r.op_code = opc;
        r.op_function = fn[2:0];
        r.reg_a = ra;
        r.reg_b = rb;
        r.cst = c;
        r.length = len;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic t_result marker_at(input logic [31:0] addr);
        return make_result(KIND_MARKER, addr, NO_OPC, FN_PLAIN, NO_REG, NO_REG, '0, LEN_NONE);
    endfunction

    // instruction length, or zero when the window does not hold a whole instruction
    function automatic logic [3:0] instr_size(input t_window w, input logic [3:0] n,
            output logic [3:0] ra, output logic [3:0] rb, output logic [63:0] c);
        logic [3:0] ic, fn, hi, lo, size;
        bit fn_ok;
        ic = w[0][7:4];
        fn = w[0][3:0];
        hi = w[1][7:4];
        lo = w[1][3:0];
        ra = NO_REG;
        rb = NO_REG;
        c = '0;
        size = LEN_NONE;
        // only conditional moves, alu ops and jumps carry a function nibble
        if (ic == IC_CMOV || ic == IC_OPQ || ic == IC_JXX) fn_ok = (fn <= FN_MAX);
        else fn_ok = (fn == FN_PLAIN);
        if (ic < IC_LIMIT && fn_ok) begin
            case (ic)
                IC_HALT, IC_NOP, IC_RET: size = LEN_ONE;
                IC_CMOV, IC_OPQ: begin
                    if (n >= LEN_TWO && hi <= REG_MAX && lo <= REG_MAX) size = LEN_TWO;
                end
                IC_IRMOV: begin
                    if (n >= LEN_LONG && hi == NO_REG && lo <= REG_MAX) size = LEN_LONG;
                end
                IC_RMMOV, IC_MRMOV: begin
                    if (n >= LEN_LONG && hi <= REG_MAX && lo <= REG_MAX) size = LEN_LONG;
                end
                IC_JXX, IC_CALL: begin
                    if (n >= LEN_JUMP) size = LEN_JUMP;
                end
                default: begin
                    if (n >= LEN_TWO && hi <= REG_MAX && lo == NO_REG) size = LEN_TWO;
                end
            endcase
        end
        // register byte and constant only on a good decode
        if (size == LEN_TWO || size == LEN_LONG) begin
            ra = hi;
            rb = lo;
        end
        if (size == LEN_LONG) c = quad_from(w, 2);
        if (size == LEN_JUMP) c = quad_from(w, 1);
        return size;
    endfunction

    // advance the decoder state by one window and queue the results it gives
    task automatic decode_window(input t_window w, input logic [3:0] raw_count);
        t_result batch[$];
        t_result r;
        logic [3:0] n, ic, ra, rb, len;
        logic [63:0] c;
        logic [31:0] addr;
        addr = dec_addr;
        n = (raw_count > NUM_BYTES) ? 4'(NUM_BYTES) : raw_count;
        ic = w[0][7:4];
        if (dec_done) begin
            // stream already ended, nothing comes out
        end else if (n == COUNT_END) begin
            dec_done = 1'b1;
            if (dec_halt_run || (dec_at_start && addr != '0)) batch.push_back(marker_at(addr));
            dec_halt_run = 1'b0;
            dec_prev_halt = 1'b0;
        end else if (dec_at_start && w[0] == 8'h00) begin
            // leading zero byte
            batch.push_back(make_result(KIND_SKIP, addr, NO_OPC, FN_PLAIN, NO_REG, NO_REG,
                '0, LEN_ONE));
            dec_addr = addr + 32'd1;
        end else begin
            if (dec_at_start) begin
                dec_at_start = 1'b0;
                if (addr != '0) batch.push_back(marker_at(addr));
            end
            // any non-halt icode closes a halt run
            if (ic != IC_HALT) begin
                if (dec_halt_run) batch.push_back(marker_at(addr));
                dec_halt_run = 1'b0;
                dec_prev_halt = 1'b0;
            end
            len = instr_size(w, n, ra, rb, c);
            if (len != LEN_NONE) begin
                if (ic == IC_HALT && dec_prev_halt) begin
                    dec_halt_run = 1'b1;
                    batch.push_back(make_result(KIND_SKIP, addr, NO_OPC, FN_PLAIN, NO_REG,
                        NO_REG, '0, LEN_ONE));
                end else begin
                    if (ic == IC_HALT) dec_prev_halt = 1'b1;
                    batch.push_back(make_result(KIND_INSTR, addr, ic, w[0][3:0], ra, rb, c,
                        len));
                end
            end else if (addr[2:0] == 3'b000 && n >= LEN_QUAD) begin
                len = LEN_QUAD;
                batch.push_back(make_result(KIND_QUAD, addr, NO_OPC, FN_PLAIN, NO_REG, NO_REG,
                    quad_from(w, 0), len));
            end else begin
                len = LEN_ONE;
                batch.push_back(make_result(KIND_BYTE, addr, NO_OPC, FN_PLAIN, NO_REG, NO_REG,
                    {56'd0, w[0]}, len));
            end
            dec_addr = addr + 32'(len);
        end
        for (int i = 0; i < batch.size(); i++) begin
            r = batch[i];
            r.last = (i == batch.size() - 1);
            results_due.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got_v,
            input logic [63:0] want_v, input logic [31:0] at);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s at %h: got %h, expected %h", name, at, got_v, want_v));
    endtask

    // send one window transaction, with bursts and gaps when enabled
    task automatic send_window(input t_window w, input logic [3:0] cnt);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 10);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        in_window <= w;
        in_count <= cnt;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!dec_done) items_sent++;
        decode_window(w, cnt);
    endtask

    // stop sending and let every due result come out
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the start offset while the block is idle
    task automatic load_start(input logic [31:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dec_addr = v;
        dec_at_start = 1'b1;
        dec_prev_halt = 1'b0;
        dec_halt_run = 1'b0;
        dec_done = 1'b0;
        image_base = v;
    endtask

    task automatic push_quad(input logic [63:0] v);
        for (int i = 0; i < 8; i++) image.push_back(v[8*i +: 8]);
    endtask

    // random program: mostly instructions, with halt runs, bad bytes and junk
    task automatic build_program(input int pieces);
        int pick;
        logic [3:0] ic, fn, ra, rb;
        image.delete();
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) image.push_back(8'h00);
        repeat (pieces) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                ic = 4'($urandom_range(0, 11));
                fn = FN_PLAIN;
                if (ic == IC_CMOV || ic == IC_OPQ || ic == IC_JXX)
                    fn = 4'($urandom_range(0, 6));
                if ($urandom_range(0, 19) == 0) fn = 4'($urandom());
                image.push_back({ic, fn});
                ra = 4'($urandom_range(0, 14));
                rb = 4'($urandom_range(0, 14));
                if (ic == IC_IRMOV) ra = NO_REG;
                if (ic == IC_PUSH || ic == IC_POP) rb = NO_REG;
                if ($urandom_range(0, 15) == 0) begin
                    ra = 4'($urandom());
                    rb = 4'($urandom());
                end
                case (ic)
                    IC_CMOV, IC_OPQ, IC_PUSH, IC_POP: image.push_back({ra, rb});
                    IC_IRMOV, IC_RMMOV, IC_MRMOV: begin
                        image.push_back({ra, rb});
                        push_quad({$urandom(), $urandom()});
                    end
                    IC_JXX, IC_CALL: push_quad({$urandom(), $urandom()});
                    default: ;
                endcase
            end else if (pick < 72) begin
                repeat ($urandom_range(1, 5)) image.push_back(8'h00);
            end else if (pick < 80) begin
                image.push_back({IC_HALT, 4'($urandom_range(1, 15))});
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 12)) image.push_back(8'($urandom()));
            end else begin
                image.push_back({4'($urandom_range(12, 15)), 4'($urandom())});
            end
        end
    endtask

    // walk the image at the tracked address, ending with a zero count unless cut off
    task automatic feed_image(input int max_items, input int pause_at);
        t_window w;
        logic [31:0] off;
        logic [3:0] cnt;
        int remaining, sent;
        bit stop;
        sent = 0;
        stop = 1'b0;
        cnt = 4'd1;
        while (!stop) begin
            off = dec_addr - image_base;
            if (max_items != 0 && sent == max_items) begin
                stop = 1'b1;
            end else begin
                remaining = (off >= image.size()) ? 0 : image.size() - int'(off);
                cnt = (remaining >= NUM_BYTES) ? 4'(NUM_BYTES) : 4'(remaining);
                if (remaining >= NUM_BYTES && $urandom_range(0, 7) == 0)
                    cnt = 4'($urandom_range(11, 15));
                for (int i = 0; i < NUM_BYTES; i++)
                    w[i] = (i < remaining) ? image[off + i] : 8'($urandom());
                // sender waits for the block to drain
                if (sent == pause_at) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (results_due.size() != 0) @(posedge i_clk);
                end
                send_window(w, cnt);
                sent++;
                if (cnt == COUNT_END) stop = 1'b1;
            end
        end
        // up to two windows after the end, which must give nothing
        if (cnt == COUNT_END) begin
            repeat ($urandom_range(0, 2)) begin
                for (int i = 0; i < NUM_BYTES; i++) w[i] = 8'($urandom());
                send_window(w, 4'($urandom()));
            end
        end
    endtask

    // every opcode, halt suppression, invalid halt function and a cut-off tail
    task automatic test_directed_opcodes();
        image.delete();
        image_base = '0;
        image = {8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h03, 8'h00, 8'h30, 8'hF3};
        push_quad(64'hFFFF_FFFF_FFFF_FFFF);
        image.push_back(8'h40);
        image.push_back(8'h12);
        push_quad(64'h0123_4567_89AB_CDEF);
        image.push_back(8'h50);
        image.push_back(8'h3E);
        push_quad({$urandom(), $urandom()});
        image.push_back(8'h66);
        image.push_back(8'hEE);
        image.push_back(8'h26);
        image.push_back(8'h0E);
        image.push_back(8'h76);
        push_quad({$urandom(), $urandom()});
        image.push_back(8'h80);
        push_quad(64'h0);
        image.push_back(8'h90);
        image.push_back(8'hA0);
        image.push_back(8'h5F);
        image.push_back(8'hB0);
        image.push_back(8'hEF);
        image.push_back(8'hF0);
        image.push_back(8'h30);
        image.push_back(8'hF2);
        image.push_back(8'h11);
        feed_image(0, -1);
    endtask

    // address wrap while skipping zeros, empty stream, halt run at end of stream
    task automatic test_stream_edges();
        load_start(32'hFFFF_FFFF);
        image = {8'h00, 8'h00};
        feed_image(0, -1);
        load_start(32'h0);
        image.delete();
        feed_image(0, -1);
        load_start(32'h10);
        image = {8'h10, 8'h00, 8'h00, 8'h00};
        feed_image(0, -1);
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        load_start({29'($urandom_range(0, 32'hFFFF)), 3'b000});
        build_program(60);
        gaps_on = 1'b0;
        hold_off_left = HOLD_OFF_CYCLES;
        feed_image(0, -1);
        gaps_on = 1'b1;
    endtask

    // sender stops mid-stream until all results are out
    task automatic test_drain_pause();
        load_start($urandom_range(0, 255));
        build_program(30);
        feed_image(0, 10);
    endtask

    // random streams at random offsets, some noise, some cut off
    task automatic test_random_streams();
        logic [31:0] base;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0: base = 32'h0;
                1: base = 32'hFFFF_FFFF;
                2: base = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                3: base = $urandom();
                4: base = $urandom_range(0, 64);
                default: base = {29'($urandom_range(0, 32'h1FFF_FFFF)), 3'b000};
            endcase
            load_start(base);
            gaps_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0) begin
                image.delete();
                repeat ($urandom_range(1, 40)) image.push_back(8'($urandom()));
            end else begin
                build_program($urandom_range(1, 40));
            end
            if ($urandom_range(0, 9) == 0) feed_image($urandom_range(1, 20), -1);
            else feed_image(0, $urandom_range(0, 3) == 0 ? $urandom_range(1, 15) : -1);
        end
        gaps_on = 1'b1;
    endtask

    // receiver stall pattern, with a counted hold-off on request
    initial begin : out_stall_gen
        int phase_left;
        int stall_pct;
        phase_left = 0;
        stall_pct = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 25;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    phase_left = $urandom_range(10, 80);
                end
                phase_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // compare each result transaction with the oldest one due
    initial begin : result_check
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d at %h",
                        o_kind, o_item_address));
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", o_kind, want.kind, want.item_address);
                    check_field("item_address", o_item_address, want.item_address,
                        want.item_address);
                    check_field("op_code", o_op_code, want.op_code, want.item_address);
                    check_field("op_function", o_op_function, want.op_function,
                        want.item_address);
                    check_field("reg_a", o_reg_a, want.reg_a, want.item_address);
                    check_field("reg_b", o_reg_b, want.reg_b, want.item_address);
                    check_field("constant", o_constant, want.cst, want.item_address);
                    check_field("length", o_length, want.length, want.item_address);
                    check_field("last", o_last, want.last, want.item_address);
                end
            end
        end
    end

    // run limit
    initial begin : run_limit
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // test sequence
    initial begin : test_sequence
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_opcodes();
        test_stream_edges();
        test_backpressure();
        test_drain_pause();
        test_random_streams();
        settle();
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
